[rtl/pgu_pkg.sv]
// Package for pixel_gaussian_unary_cost: widths, register indexes, constants,
// correction table. No dependencies.
package pgu_pkg;

    localparam int PIXEL_BITS = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_BG_MEAN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FG_MEAN_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FG_MEAN_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_VAR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOG_OFS   = 3'd4;

    localparam logic [15:0] UNDERFLOW_T = 16'd9226;
    localparam logic [8:0]  LN2_Q88     = 9'd177;
    localparam int          CORR_LEN    = 50;

    function automatic logic [7:0] corr_lookup(input logic [11:0] k);
        logic [7:0] r;
        case (k)
            12'd0: r = 8'd177;  12'd1: r = 8'd162;  12'd2: r = 8'd147;
            12'd3: r = 8'd134;  12'd4: r = 8'd121;  12'd5: r = 8'd110;
            12'd6: r = 8'd99;   12'd7: r = 8'd89;   12'd8: r = 8'd80;
            12'd9: r = 8'd72;   12'd10: r = 8'd64;  12'd11: r = 8'd58;
            12'd12: r = 8'd52;  12'd13: r = 8'd46;  12'd14: r = 8'd41;
            12'd15: r = 8'd37;  12'd16: r = 8'd32;  12'd17: r = 8'd29;
            12'd18: r = 8'd26;  12'd19: r = 8'd23;  12'd20: r = 8'd20;
            12'd21: r = 8'd18;  12'd22: r = 8'd16;  12'd23: r = 8'd14;
            12'd24: r = 8'd12;  12'd25: r = 8'd11;  12'd26: r = 8'd10;
            12'd27: r = 8'd9;   12'd28: r = 8'd8;   12'd29: r = 8'd7;
            12'd30: r = 8'd6;   12'd31: r = 8'd5;   12'd32: r = 8'd5;
            12'd33: r = 8'd4;   12'd34: r = 8'd4;   12'd35: r = 8'd3;
            12'd36: r = 8'd3;   12'd37: r = 8'd2;   12'd38: r = 8'd2;
            12'd39: r = 8'd2;   12'd40: r = 8'd2;   12'd41: r = 8'd2;
            12'd42: r = 8'd1;   12'd43: r = 8'd1;   12'd44: r = 8'd1;
            12'd45: r = 8'd1;   12'd46: r = 8'd1;   12'd47: r = 8'd1;
            12'd48: r = 8'd1;   12'd49: r = 8'd1;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/pixel_gaussian_unary_cost.sv]
// Four register stages; throughput one pixel per cycle while the output is not stalled.
// Stages: distance squared, multiply by 1/(2 sigma^2), round/cap and min/diff,
// correction lookup and saturating sums. A stall freezes all stages.
// Reset (synchronous, active low aresetn) clears stage valids and loads register defaults.
// Depends on pgu_pkg.
module pixel_gaussian_unary_cost
    import pgu_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] pixel_value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata    // [15:0] background_cost, [31:16] foreground_cost
);

    logic [7:0]  bg_mean_reg, fg1_mean_reg, fg2_mean_reg;
    logic [23:0] inv_var_reg;
    logic signed [15:0] ofs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bg_mean_reg  <= 8'd0;
            fg1_mean_reg <= 8'd128;
            fg2_mean_reg <= 8'd255;
            inv_var_reg  <= 24'd32768;
            ofs_reg      <= 16'sd945;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BG_MEAN:   bg_mean_reg  <= cfg_data[7:0];
                REG_FG_MEAN_1: fg1_mean_reg <= cfg_data[7:0];
                REG_FG_MEAN_2: fg2_mean_reg <= cfg_data[7:0];
                REG_INV_VAR:   inv_var_reg  <= cfg_data;
                REG_LOG_OFS:   ofs_reg      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic advance;
    assign advance  = !v4_reg || m_tready;
    assign s_tready = advance;

    // stage 1: squared distances
    logic [PIXEL_BITS-1:0] px;
    logic [PIXEL_BITS-1:0] db, d1, d2;
    logic [15:0] sqb_reg, sq1_reg, sq2_reg;
    assign px = s_tdata[PIXEL_BITS-1:0];
    assign db = (px >= bg_mean_reg)  ? px - bg_mean_reg  : bg_mean_reg - px;
    assign d1 = (px >= fg1_mean_reg) ? px - fg1_mean_reg : fg1_mean_reg - px;
    assign d2 = (px >= fg2_mean_reg) ? px - fg2_mean_reg : fg2_mean_reg - px;

    // stage 2: products
    logic [39:0] eb_reg, e1_reg, e2_reg;

    // stage 3: round, cap, min and diff
    logic [15:0] tb_reg, tmin_reg, u_reg;
    logic [15:0] tb_c, t1_c, t2_c;

    function automatic logic [15:0] round_cap(input logic [39:0] e);
        logic [40:0] s;
        s = {1'b0, e} + 41'd32768;
        return (|s[40:32]) ? 16'hFFFF : s[31:16];
    endfunction

    assign tb_c = round_cap(eb_reg);
    assign t1_c = round_cap(e1_reg);
    assign t2_c = round_cap(e2_reg);

    // stage 4: outputs
    logic [15:0] bg_reg, fg_reg;
    logic signed [18:0] bg_sum, fg_sum;
    logic [11:0] k;
    logic [16:0] u_r;
    assign u_r    = {1'b0, u_reg} + 17'd16;
    assign k      = u_r[16:5];
    assign bg_sum = $signed({3'b000, tb_reg}) + 19'(ofs_reg);
    assign fg_sum = $signed({3'b000, tmin_reg}) - $signed({11'd0, corr_lookup(k)})
                  + 19'(ofs_reg) + $signed({10'd0, LN2_Q88});

    function automatic logic [15:0] sat16(input logic signed [18:0] v);
        if (v > 19'sd32767)       return 16'h7FFF;
        else if (v < -19'sd32768) return 16'h8000;
        else                      return v[15:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sqb_reg <= 16'(db) * 16'(db);
            sq1_reg <= 16'(d1) * 16'(d1);
            sq2_reg <= 16'(d2) * 16'(d2);
            eb_reg  <= 40'(sqb_reg) * 40'(inv_var_reg);
            e1_reg  <= 40'(sq1_reg) * 40'(inv_var_reg);
            e2_reg  <= 40'(sq2_reg) * 40'(inv_var_reg);
            tb_reg   <= tb_c;
            tmin_reg <= (t1_c < t2_c) ? t1_c : t2_c;
            u_reg    <= (t1_c < t2_c) ? t2_c - t1_c : t1_c - t2_c;
            bg_reg   <= sat16(bg_sum);
            fg_reg   <= (tmin_reg > UNDERFLOW_T) ? 16'h7FFF : sat16(fg_sum);
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {fg_reg, bg_reg};

`ifndef ASSERT_OFF
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && v3_reg |=> m_tvalid)
        else $error("item lost in pipeline");
`endif

endmodule
